[rtl/qfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfe_pkg
// Shared widths, request codes and the term result bundle of the
// quadratic form energy block.
// ----------------------------------------------------------------------------
package qfe_pkg;

   localparam int MAX_LENGTH = 64;
   localparam int IDX_W      = $clog2(MAX_LENGTH);
   localparam int LEN_W      = 7;
   localparam int VAL_W      = 32;
   localparam int SUM_W      = 64;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);

   // request kinds
   localparam logic REQ_VECTOR = 1'b0;
   localparam logic REQ_MATRIX = 1'b1;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic             vld;
      logic             sat;
      logic [SUM_W-1:0] value;
   } term_out_type;

endpackage

[rtl/qfe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/qfe_term.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfe_term
// Five-stage pipeline: signed Q32.32 term a*b*c from three Q16.16 operands,
// rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
module qfe_term
   import qfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    op_vld,
   input  logic signed [VAL_W-1:0] op_a,
   input  logic signed [VAL_W-1:0] op_b,
   input  logic signed [VAL_W-1:0] op_c,
   output term_out_type            term
);

   localparam int M1_W = 2 * VAL_W - 1;          // |a*b| <= 2^62
   localparam int LO_W = 2 * VAL_W;
   localparam int HI_W = M1_W - VAL_W + VAL_W;   // 31 x 32 bits
   localparam int P_W  = M1_W + VAL_W - 1;       // |a*b*c| <= 2^93
   localparam int Q_W  = P_W - 16;

   logic [VAL_W-1:0] mag_a, mag_b, mag_c;

   // stage 1
   logic             vld1_ff;
   logic [M1_W-1:0]  m1_ff;
   logic [VAL_W-1:0] magc_ff;
   logic             neg1_ff;
   // stage 2
   logic             vld2_ff;
   logic [LO_W-1:0]  lo_ff;
   logic [HI_W-1:0]  hi_ff;
   logic             neg2_ff;
   // stage 3
   logic             vld3_ff;
   logic [P_W-1:0]   p_ff;
   logic             neg3_ff;
   // stage 4
   logic             vld4_ff;
   logic [SUM_W-1:0] q_ff;
   logic             sat4_ff;
   logic             neg4_ff;
   // stage 5
   term_out_type     term_ff;

   logic [P_W-1:0]   rounded;
   logic [Q_W-1:0]   q_wide;
   logic [SUM_W-1:0] limit;
   logic [LO_W-1:0]  m1_full;

   function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
      magnitude = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
   endfunction

   always_comb begin
      mag_a   = magnitude(op_a);
      mag_b   = magnitude(op_b);
      mag_c   = magnitude(op_c);
      m1_full = LO_W'(mag_a) * LO_W'(mag_b);
      rounded = p_ff + P_W'(16'h8000);
      q_wide  = rounded[P_W-1:16];
      limit   = neg3_ff ? SUM_MIN : SUM_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff     <= 1'b0;
         vld2_ff     <= 1'b0;
         vld3_ff     <= 1'b0;
         vld4_ff     <= 1'b0;
         term_ff.vld <= 1'b0;
      end else begin
         vld1_ff     <= op_vld;
         vld2_ff     <= vld1_ff;
         vld3_ff     <= vld2_ff;
         vld4_ff     <= vld3_ff;
         term_ff.vld <= vld4_ff;
      end

      // magnitudes and first product
      m1_ff   <= m1_full[M1_W-1:0];
      magc_ff <= mag_c;
      neg1_ff <= op_a[VAL_W-1] ^ op_b[VAL_W-1] ^ op_c[VAL_W-1];

      // split the wide product into two partials
      lo_ff   <= LO_W'(m1_ff[VAL_W-1:0]) * LO_W'(magc_ff);
      hi_ff   <= HI_W'(m1_ff[M1_W-1:VAL_W]) * HI_W'(magc_ff);
      neg2_ff <= neg1_ff;

      // combine partials
      p_ff    <= P_W'(lo_ff) + P_W'({hi_ff, {VAL_W{1'b0}}});
      neg3_ff <= neg2_ff;

      // round to Q32.32 and clip the magnitude
      if (q_wide > Q_W'(limit)) begin
         q_ff    <= limit;
         sat4_ff <= 1'b1;
      end else begin
         q_ff    <= q_wide[SUM_W-1:0];
         sat4_ff <= 1'b0;
      end
      neg4_ff <= neg3_ff;

      // apply sign
      term_ff.value <= neg4_ff ? (SUM_W'(0) - q_ff) : q_ff;
      term_ff.sat   <= sat4_ff;
   end

   assign term = term_ff;

endmodule

[rtl/quadratic_form_energy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_form_energy
// Streaming E = f^T L f: vector elements load into a store, matrix entries
// add f[i]*L[i][j]*f[j] to a saturating Q32.32 sum, emitted on the last entry.
// ----------------------------------------------------------------------------
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  -------------------------
//   request  req_type/row_index/col_index/value/last  beat on start & !busy
//   result   rsp_energy, rsp_overflow                 one-cycle rsp_valid strobe
//   config   csr_vector_length                        beat on csr_valid & ready
//
// A vector load is written into the store at the accept edge and busy stays
// low. A matrix entry holds busy from its accept edge to its accumulate edge,
// so a new entry is taken only once the last is through: the accept edge reads
// the store, the term multiply/round pipeline runs through its stages, and busy
// drops at the accumulate edge. The result strobe rises at the accumulate edge.
// Reset is synchronous; it clears the sum, the flag and the length (to 64).
// The vector store is not cleared; reading an unwritten element is undefined.
// The receiver cannot stall: a result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module quadratic_form_energy
   import qfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic [IDX_W-1:0]        req_row_index,
   input  logic [IDX_W-1:0]        req_col_index,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    req_last,
   // result channel
   output logic                    rsp_valid,
   output logic signed [SUM_W-1:0] rsp_energy,
   output logic                    rsp_overflow,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LEN_W-1:0]        csr_vector_length
);

   logic accept, load_wr, entry_rd;

   logic [LEN_W-1:0] len_ff;
   logic             busy_ff;
   logic             rd_vld_ff;
   logic [VAL_W-1:0] value_ff;
   logic             last_ff;
   logic             in_range_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             sat_ff;
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] rsp_energy_ff;
   logic             rsp_overflow_ff;

   logic [VAL_W-1:0] f_row, f_col;
   term_out_type     term;

   logic [SUM_W-1:0] add_raw, sum_in;
   logic             add_ovf, sat_in;

   assign accept   = start & ~busy_ff;
   assign load_wr  = accept & (req_type == REQ_VECTOR);
   assign entry_rd = accept & (req_type == REQ_MATRIX);

   // two copies of the store: one read port each for row and column element
   qfe_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_store_row (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_row_index),
      .wr_data (req_value),
      .rd_en   (entry_rd),
      .rd_addr (req_row_index),
      .rd_data (f_row)
   );

   qfe_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_store_col (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_row_index),
      .wr_data (req_value),
      .rd_en   (entry_rd),
      .rd_addr (req_col_index),
      .rd_data (f_col)
   );

   qfe_term u_term (
      .clock  (clock),
      .reset  (reset),
      .op_vld (rd_vld_ff),
      .op_a   (f_row),
      .op_b   (value_ff),
      .op_c   (f_col),
      .term   (term)
   );

   // saturating accumulate; out-of-range entries leave the sum alone
   always_comb begin
      add_raw = sum_ff + term.value;
      add_ovf = (sum_ff[SUM_W-1] == term.value[SUM_W-1]) &&
                (add_raw[SUM_W-1] != sum_ff[SUM_W-1]);
      sum_in  = sum_ff;
      sat_in  = sat_ff;
      if (in_range_ff) begin
         sum_in = add_ovf ? (term.value[SUM_W-1] ? SUM_MIN : SUM_MAX) : add_raw;
         sat_in = sat_ff | term.sat | add_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         busy_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            len_ff <= csr_vector_length;
         end
         rd_vld_ff    <= entry_rd;
         rsp_valid_ff <= 1'b0;
         if (entry_rd) begin
            busy_ff <= 1'b1;
         end
         if (term.vld) begin
            // entry done: drop busy, emit and clear on last
            busy_ff <= 1'b0;
            if (last_ff) begin
               rsp_valid_ff <= 1'b1;
               sum_ff       <= '0;
               sat_ff       <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               sat_ff <= sat_in;
            end
         end
      end

      // hold entry payload while it is in flight
      if (entry_rd) begin
         value_ff    <= req_value;
         last_ff     <= req_last;
         in_range_ff <= (LEN_W'(req_row_index) < len_ff) &&
                        (LEN_W'(req_col_index) < len_ff);
      end
      if (term.vld) begin
         rsp_energy_ff   <= sum_in;
         rsp_overflow_ff <= sat_in;
      end
   end

   assign busy         = busy_ff;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_energy   = rsp_energy_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // a store read and a finished term only occur inside a busy window
   a_rd_in_busy : assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> busy_ff)
      else $error("store read outside busy window");

   a_term_in_busy : assert property (@(posedge clock) disable iff (reset)
      term.vld |-> busy_ff)
      else $error("term finished while idle");

   // a result leaves the sum and flag cleared
   a_clear_after_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (sum_ff == '0 && !sat_ff))
      else $error("sum not cleared after emission");

   // a result strobe follows a finished last entry
   a_rsp_from_term : assert property (@(posedge clock) disable iff (reset)
      term.vld && last_ff |=> rsp_valid_ff)
      else $error("last entry produced no result");

endmodule

[dv/tb_quadratic_form_energy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_form_energy
// Self-checking bench for the streaming f^T L f accumulator. A queue of
// request beats feeds a clocked driver. Every accepted beat runs through a
// bit-true predictor of the Q16.16 term, the half-away rounding and the
// saturating Q32.32 sum. A clocked monitor checks each result strobe against
// the oldest predicted energy. The stimulus is a directed pass over rounding,
// saturation and range corners, then random load/entry sequences over many
// vector lengths.
// ----------------------------------------------------------------------------
module tb_quadratic_form_energy;
   import qfe_pkg::*;

   // one request beat plus the idle cycles that the driver inserts before it
   typedef struct {
      logic             kind;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
      logic             last;
      int unsigned      gap;
   } stream_word_type;

   typedef struct {
      logic [SUM_W-1:0] energy;
      logic             overflow;
   } energy_result_type;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    start             = 1'b0;
   logic                    busy;
   logic                    req_type          = REQ_VECTOR;
   logic [IDX_W-1:0]        req_row_index     = '0;
   logic [IDX_W-1:0]        req_col_index     = '0;
   logic [VAL_W-1:0]        req_value         = '0;
   logic                    req_last          = 1'b0;
   logic                    rsp_valid;
   logic signed [SUM_W-1:0] rsp_energy;
   logic                    rsp_overflow;
   logic                    csr_valid         = 1'b0;
   logic                    csr_ready;
   logic [LEN_W-1:0]        csr_vector_length = LEN_RESET;

   // stimulus and scoreboard storage
   stream_word_type   words_to_send[$];
   energy_result_type energy_due[$];
   stream_word_type   on_bus;
   stream_word_type   staged;
   stream_word_type   popped;
   logic              have_item = 1'b0;
   int unsigned       gap_left  = 0;
   int                fault_count = 0;

   // predictor state: element store, running sum, clip flag, length
   logic [VAL_W-1:0] f_store[MAX_LENGTH];
   logic [SUM_W-1:0] sum_acc     = '0;
   logic             sum_clipped = 1'b0;
   logic [LEN_W-1:0] active_len  = LEN_RESET;

   // generator state: length in force, elements loaded so far, gap policy
   logic [LEN_W-1:0]      gen_len = LEN_RESET;
   bit [MAX_LENGTH-1:0]   written = '0;
   bit                    burst_calm = 1'b0;
   int                    words_made = 0;

   quadratic_form_energy dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_energy        (rsp_energy),
      .rsp_overflow      (rsp_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_vector_length (csr_vector_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (every beat gapped and busy).
   initial begin
      #2_000_000;
      $display("tb_quadratic_form_energy: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
      // two's complement magnitude; the most negative value maps to 2^31
      return v[VAL_W-1] ? (~v + 1'b1) : v;
   endfunction

   // Add f[i]*L[i][j]*f[j] to the running sum. The exact product is Q48.48;
   // round its magnitude half away from zero into Q32.32, clip, then sign it.
   function automatic void add_term(input logic [VAL_W-1:0] fi,
                                    input logic [VAL_W-1:0] lij,
                                    input logic [VAL_W-1:0] fj);
      logic [95:0]      prod;
      logic [95:0]      mag;
      logic [95:0]      cap;
      logic [SUM_W-1:0] term;
      logic [SUM_W-1:0] total;
      logic             neg;
      neg  = fi[VAL_W-1] ^ lij[VAL_W-1] ^ fj[VAL_W-1];
      prod = 96'(magnitude(fi)) * 96'(magnitude(lij)) * 96'(magnitude(fj));
      mag  = (prod + 96'h8000) >> 16;
      cap  = neg ? {32'd0, SUM_MIN} : {32'd0, SUM_MAX};
      if (mag > cap) begin
         mag         = cap;
         sum_clipped = 1'b1;
      end
      term  = neg ? -mag[SUM_W-1:0] : mag[SUM_W-1:0];
      total = sum_acc + term;
      // same-sign operands whose sum flips sign: clip to the rail of the term
      if (sum_acc[SUM_W-1] == term[SUM_W-1] && total[SUM_W-1] != term[SUM_W-1]) begin
         total       = term[SUM_W-1] ? SUM_MIN : SUM_MAX;
         sum_clipped = 1'b1;
      end
      sum_acc = total;
   endfunction

   // Apply one accepted beat; queue the energy when it closes a sum.
   function automatic void take_word(input stream_word_type w);
      if (w.kind == REQ_VECTOR) begin
         f_store[w.row] = w.value;
      end else begin
         // indices at or past the length contribute nothing (length 0: all)
         if (w.row < active_len && w.col < active_len)
            add_term(f_store[w.row], w.value, f_store[w.col]);
         if (w.last) begin
            energy_due.push_back('{energy: sum_acc, overflow: sum_clipped});
            sum_acc     = '0;
            sum_clipped = 1'b0;
         end
      end
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s", $time, msg);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: hold a beat until busy is low, then advance to the next one
   // ------------------------------------------------------------------------
   task automatic present(input stream_word_type w);
      on_bus        <= w;
      req_type      <= w.kind;
      req_row_index <= w.row;
      req_col_index <= w.col;
      req_value     <= w.value;
      req_last      <= w.last;
      start         <= 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         have_item <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (start && !busy)
            take_word(on_bus);
         if (start && busy) begin
            // hold the beat: it has not been taken yet
         end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (have_item) begin
            present(staged);
            have_item <= 1'b0;
         end else if (words_to_send.size() != 0) begin
            popped = words_to_send.pop_front();
            if (popped.gap == 0) begin
               present(popped);
            end else begin
               // drop start for the drawn number of cycles, then present
               staged    <= popped;
               have_item <= 1'b1;
               gap_left  <= popped.gap - 1;
               start     <= 1'b0;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: a result lives for one cycle, so check it at the edge ending it
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      energy_result_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (energy_due.size() == 0) begin
            log_fault($sformatf("result with none due: energy %h overflow %b",
                                rsp_energy, rsp_overflow));
         end else begin
            due = energy_due.pop_front();
            if (rsp_energy !== due.energy || rsp_overflow !== due.overflow)
               log_fault($sformatf("energy exp %h got %h, overflow exp %b got %b",
                                   due.energy, rsp_energy, due.overflow, rsp_overflow));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_word(input logic kind, input int row, input int col,
                            input logic [VAL_W-1:0] value, input logic last);
      stream_word_type w;
      w.kind  = kind;
      w.row   = IDX_W'(row);
      w.col   = IDX_W'(col);
      w.value = value;
      w.last  = last;
      w.gap   = burst_calm ? 0 : $urandom_range(0, 3);
      words_to_send.push_back(w);
      words_made++;
   endtask

   // Load an element; column and last are don't-care on a load, so randomize.
   task automatic load_element(input int idx, input logic [VAL_W-1:0] value);
      push_word(REQ_VECTOR, idx, $urandom_range(0, MAX_LENGTH - 1), value,
                1'($urandom_range(0, 1)));
      written[idx] = 1'b1;
   endtask

   // Mostly small Q16.16 values so sums stay in range; corners and full-width
   // words exercise rounding and both kinds of clipping.
   function automatic logic [VAL_W-1:0] draw_value();
      logic [18:0] s;
      s = 19'($urandom());
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2: begin
            case ($urandom_range(0, 6))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               4: return 32'hFFFF_FFFF;
               5: return 32'h0000_8000;
               default: return 32'h0001_0000;
            endcase
         end
         default: return {{(VAL_W - 19){s[18]}}, s};
      endcase
   endfunction

   function automatic int pick_loaded(input int eff);
      int j;
      do j = $urandom_range(0, eff - 1); while (!written[j]);
      return j;
   endfunction

   // Push one matrix entry. In-range entries only touch loaded elements;
   // out-of-range ones add nothing, so any index is fine there.
   task automatic push_entry(input logic closing);
      int eff;
      int r;
      int c;
      int t;
      eff = (gen_len > MAX_LENGTH) ? MAX_LENGTH : gen_len;
      if (eff < MAX_LENGTH && (eff == 0 || $urandom_range(0, 5) == 0)) begin
         r = $urandom_range(eff, MAX_LENGTH - 1);
         c = $urandom_range(0, MAX_LENGTH - 1);
         if ($urandom_range(0, 1)) begin
            t = r;
            r = c;
            c = t;
         end
      end else begin
         r = pick_loaded(eff);
         c = pick_loaded(eff);
      end
      push_word(REQ_MATRIX, r, c, draw_value(), closing);
   endtask

   // Wait until the driver is drained, the block is quiet and every due
   // energy has arrived, then let the entry pipeline run dry.
   task automatic settle();
      @(negedge clock);
      while (words_to_send.size() != 0 || have_item || start ||
             busy !== 1'b0 || energy_due.size() != 0)
         @(negedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Write the length register while the block is idle.
   task automatic retune(input logic [LEN_W-1:0] len);
      settle();
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_vector_length <= len;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      active_len = len;
      gen_len    = len;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      int lim;
      int n_terms;
      int idx;
      logic closing;

      foreach (f_store[i])
         f_store[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: corner operands at the reset length of 64.
      load_element(0, 32'h7FFF_FFFF);
      load_element(1, 32'h8000_0000);
      load_element(2, 32'h0001_0000);      // 1.0
      load_element(3, 32'hFFFF_0000);      // -1.0
      load_element(4, 32'h0000_0000);
      load_element(5, 32'h0000_0001);      // smallest step
      load_element(6, 32'hFFFF_FFFF);      // minus smallest step
      load_element(63, 32'h0000_8000);     // top index, 0.5
      push_word(REQ_MATRIX, 2, 2, 32'h0001_0000, 1'b1);         // exactly 1.0
      push_word(REQ_MATRIX, 3, 2, 32'hFFFF_0000, 1'b0);
      push_word(REQ_MATRIX, 63, 63, 32'h7FFF_FFFF, 1'b1);
      push_word(REQ_MATRIX, 0, 0, 32'h7FFF_FFFF, 1'b1);         // term clips high
      push_word(REQ_MATRIX, 1, 1, 32'h8000_0000, 1'b1);         // term clips low
      // three terms near 2^62 each: the sum itself clips
      push_word(REQ_MATRIX, 0, 2, 32'h7FFF_FFFF, 1'b0);
      push_word(REQ_MATRIX, 0, 2, 32'h7FFF_FFFF, 1'b0);
      push_word(REQ_MATRIX, 2, 0, 32'h7FFF_FFFF, 1'b1);
      // rounding: a half rounds away from zero on both signs, below half drops
      push_word(REQ_MATRIX, 5, 6, 32'h0000_8000, 1'b1);
      push_word(REQ_MATRIX, 5, 5, 32'h0000_8000, 1'b1);
      push_word(REQ_MATRIX, 5, 5, 32'h0000_7FFF, 1'b1);
      push_word(REQ_MATRIX, 4, 63, 32'h8000_0000, 1'b1);        // zero operand

      // Length zero ignores every entry, yet last still emits.
      retune(0);
      push_word(REQ_MATRIX, 0, 0, 32'h0001_0000, 1'b1);
      // Length one: column 1 is out of range, the diagonal entry counts.
      retune(1);
      push_word(REQ_MATRIX, 0, 1, 32'h7FFF_FFFF, 1'b0);
      push_word(REQ_MATRIX, 0, 0, 32'h0001_0000, 1'b1);
      // Lengths past 64 act as 64.
      retune(127);
      push_word(REQ_MATRIX, 63, 0, 32'hFFFF_0000, 1'b1);

      // Random: load a few elements, stream entries, close with last. Sprinkle
      // stray loads, early closes, unclosed runs and out-of-range entries.
      words_made = 0;
      while (words_made < 1950) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 6))
               0: retune(0);
               1: retune(1);
               2: retune(64);
               3: retune(127);
               default: retune(LEN_W'($urandom_range(2, 63)));
            endcase
         end
         burst_calm = ($urandom_range(0, 2) == 0);
         lim = (gen_len == 0 || gen_len > MAX_LENGTH) ? MAX_LENGTH : gen_len;
         // first load lands below the length (anywhere at length 0) so entries have operands
         load_element($urandom_range(0, lim - 1), draw_value());
         repeat ($urandom_range(0, 5)) begin
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_LENGTH - 1)
                                               : $urandom_range(0, lim - 1);
            load_element(idx, draw_value());
         end
         n_terms = $urandom_range(1, 12);
         for (int k = 0; k < n_terms; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               load_element($urandom_range(0, MAX_LENGTH - 1), draw_value());
            end else begin
               closing = (k == n_terms - 1) ? ($urandom_range(0, 9) != 0)
                                            : ($urandom_range(0, 11) == 0);
               push_entry(closing);
            end
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("tb_quadratic_form_energy: clean");
      end else begin
         $display("tb_quadratic_form_energy: errors");
      end
      $finish;
   end

endmodule
